@@ sv/grr_pkg.sv @@
package grr_pkg;

    // Widths fixed by the field and register formats.
    localparam int HALF_W  = 6;
    localparam int IDX_W   = 6;
    localparam int DATA_W  = 32;
    localparam int STEP_W  = 32;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 32;
    localparam int S_DATA_W = 48;

    // Grid sizes reach 2 * 63 cells, ring lengths stay below 512.
    localparam int DIM_W = 8;
    localparam int LEN_W = 9;
    localparam int CNT_W = 5;

    // Request kinds carried on tuser.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_A_W-1:0] REG_HALF_ROWS    = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_HALF_COLS    = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_ROTATE_STEPS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEOM,
        ST_DIV,
        ST_MODQ,
        ST_MAP,
        ST_READ,
        ST_LOAD
    } grr_state_t;

endpackage

@@ sv/grid_ring_rotate.sv @@
// Write requests give no result and leave the block ready for the next request.
// A read inside the grid computes the ring geometry, runs the restoring divider for
// rotate_steps mod ring length, then does position wrap, cell mapping, the grid memory read
// and the output load, which waits until the output register is free. A read outside the
// grid goes straight to the output load and returns zero. aresetn is synchronous and active
// low; it sets the sizes to 1 and rotate_steps to 0. The grid memory is not cleared.
module grid_ring_rotate #(
    parameter int MAX_HALF_ROWS = 32,
    parameter int MAX_HALF_COLS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [grr_pkg::CFG_A_W-1:0]       cfg_addr,
    input  logic [grr_pkg::CFG_D_W-1:0]       cfg_wdata,

    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [grr_pkg::S_DATA_W-1:0]      s_tdata,   // row[5:0], col[11:6], value[43:12]
    input  logic                              s_tuser,   // cmd[0]

    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [grr_pkg::DATA_W-1:0]        m_tdata    // rotated_value[31:0]
);

    localparam int STORE_ROWS = 2 * MAX_HALF_ROWS;
    localparam int STORE_COLS = 2 * MAX_HALF_COLS;
    localparam int DEPTH      = STORE_ROWS * STORE_COLS;
    localparam int AW         = $clog2(DEPTH);

    localparam int DIM_W = grr_pkg::DIM_W;
    localparam int LEN_W = grr_pkg::LEN_W;

    // Grid memory.
    logic [grr_pkg::DATA_W-1:0] grid_mem [DEPTH];

    grr_pkg::grr_state_t state_reg, state_next;

    logic [grr_pkg::HALF_W-1:0] half_rows_reg, half_cols_reg;
    logic [grr_pkg::STEP_W-1:0] rotate_steps_reg;

    logic [grr_pkg::IDX_W-1:0]  row_reg, col_reg;
    logic                       zero_reg;
    logic [DIM_W-1:0]           lv_reg, h_reg, w_reg, sr_reg, sc_reg;
    logic [LEN_W-1:0]           len_reg, p_reg, rem_reg, q_reg;
    logic [grr_pkg::STEP_W-1:0] dvd_reg;
    logic [grr_pkg::CNT_W-1:0]  cnt_reg;
    logic [grr_pkg::DATA_W-1:0] rd_data_reg;
    logic                       m_tvalid_reg;
    logic [grr_pkg::DATA_W-1:0] m_tdata_reg;

    logic                       s_accept;
    logic [grr_pkg::IDX_W-1:0]  in_row, in_col;
    logic [grr_pkg::DATA_W-1:0] in_value;
    logic [grr_pkg::HALF_W-1:0] hr_eff, hc_eff;
    logic [DIM_W-1:0]           nr, nc;
    logic                       in_grid;
    logic                       mem_we;
    logic [AW-1:0]              wr_addr, rd_addr;
    logic                       load_out;

    // Geometry and mapping terms.
    logic [DIM_W-1:0] g_r, g_c, g_m1, g_m2, g_lv, g_h, g_w;
    logic [LEN_W-1:0] g_len, g_p, lr, lc, llv, lh, lw;
    logic [LEN_W:0]   div_trial;
    logic [LEN_W:0]   q_sum;
    logic [LEN_W-1:0] mlv, mh, mw, mq, msr, msc;

    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[11:6];
    assign in_value = s_tdata[43:12];
    assign s_accept = s_tvalid && s_tready;

    // Effective half sizes: zero reads as one, large values saturate.
    always_comb begin
        if (half_rows_reg == '0) begin
            hr_eff = grr_pkg::HALF_W'(1);
        end else if (int'(half_rows_reg) > MAX_HALF_ROWS) begin
            hr_eff = grr_pkg::HALF_W'(MAX_HALF_ROWS);
        end else begin
            hr_eff = half_rows_reg;
        end
        if (half_cols_reg == '0) begin
            hc_eff = grr_pkg::HALF_W'(1);
        end else if (int'(half_cols_reg) > MAX_HALF_COLS) begin
            hc_eff = grr_pkg::HALF_W'(MAX_HALF_COLS);
        end else begin
            hc_eff = half_cols_reg;
        end
    end

    assign nr      = DIM_W'({hr_eff, 1'b0});
    assign nc      = DIM_W'({hc_eff, 1'b0});
    assign in_grid = (DIM_W'(in_row) < nr) && (DIM_W'(in_col) < nc);

    assign mem_we  = s_accept && (s_tuser == grr_pkg::CMD_WRITE) && in_grid;
    assign wr_addr = AW'(int'(in_row) * STORE_COLS + int'(in_col));
    assign rd_addr = AW'(int'(sr_reg) * STORE_COLS + int'(sc_reg));

    // Ring of the queried cell, its shape and its clockwise position.
    always_comb begin
        g_r   = DIM_W'(row_reg);
        g_c   = DIM_W'(col_reg);
        g_m1  = (g_r < g_c) ? g_r : g_c;
        g_m2  = ((nr - 1'b1 - g_r) < (nc - 1'b1 - g_c)) ? (nr - 1'b1 - g_r)
                                                          : (nc - 1'b1 - g_c);
        g_lv  = (g_m1 < g_m2) ? g_m1 : g_m2;
        g_h   = nr - {g_lv[DIM_W-2:0], 1'b0};
        g_w   = nc - {g_lv[DIM_W-2:0], 1'b0};
        lr    = LEN_W'(g_r);
        lc    = LEN_W'(g_c);
        llv   = LEN_W'(g_lv);
        lh    = LEN_W'(g_h);
        lw    = LEN_W'(g_w);
        g_len = ((lh + lw) << 1) - LEN_W'(4);
        if (lr == llv) begin
            g_p = lc - llv;
        end else if (lc == llv + lw - 1'b1) begin
            g_p = (lw - 1'b1) + (lr - llv);
        end else if (lr == llv + lh - 1'b1) begin
            g_p = (lw - 1'b1) + (lh - 1'b1) + (llv + lw - 1'b1 - lc);
        end else begin
            g_p = ((lw - 1'b1) << 1) + (lh - 1'b1) + (llv + lh - 1'b1 - lr);
        end
    end

    // One restoring division step and the position wrap.
    assign div_trial = {rem_reg, dvd_reg[grr_pkg::STEP_W-1]};
    assign q_sum     = {1'b0, p_reg} + {1'b0, rem_reg};

    // Shifted position back to a cell of the ring.
    always_comb begin
        mlv = LEN_W'(lv_reg);
        mh  = LEN_W'(h_reg);
        mw  = LEN_W'(w_reg);
        mq  = q_reg;
        if (mq < mw) begin
            msr = mlv;
            msc = mlv + mq;
        end else if (mq < mw + mh - 1'b1) begin
            msr = mlv + mq - (mw - 1'b1);
            msc = mlv + mw - 1'b1;
        end else if (mq < ((mw - 1'b1) << 1) + mh) begin
            msr = mlv + mh - 1'b1;
            msc = mlv + mw - 1'b1 - (mq - (mw - 1'b1) - (mh - 1'b1));
        end else begin
            msr = mlv + mh - 1'b1 - (mq - ((mw - 1'b1) << 1) - (mh - 1'b1));
            msc = mlv;
        end
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= grr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            grr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && (s_tuser == grr_pkg::CMD_READ)) begin
                    state_next = in_grid ? grr_pkg::ST_GEOM : grr_pkg::ST_LOAD;
                end
            end
            grr_pkg::ST_GEOM: state_next = grr_pkg::ST_DIV;
            grr_pkg::ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = grr_pkg::ST_MODQ;
                end
            end
            grr_pkg::ST_MODQ: state_next = grr_pkg::ST_MAP;
            grr_pkg::ST_MAP:  state_next = grr_pkg::ST_READ;
            grr_pkg::ST_READ: state_next = grr_pkg::ST_LOAD;
            grr_pkg::ST_LOAD: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = grr_pkg::ST_IDLE;
                end
            end
            default: state_next = grr_pkg::ST_IDLE;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_rows_reg    <= grr_pkg::HALF_W'(1);
            half_cols_reg    <= grr_pkg::HALF_W'(1);
            rotate_steps_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                grr_pkg::REG_HALF_ROWS:    half_rows_reg    <= cfg_wdata[grr_pkg::HALF_W-1:0];
                grr_pkg::REG_HALF_COLS:    half_cols_reg    <= cfg_wdata[grr_pkg::HALF_W-1:0];
                grr_pkg::REG_ROTATE_STEPS: rotate_steps_reg <= cfg_wdata[grr_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Read datapath: geometry, divider, wrap and mapping.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            row_reg  <= in_row;
            col_reg  <= in_col;
            zero_reg <= !in_grid;
        end
        if (state_reg == grr_pkg::ST_GEOM) begin
            lv_reg  <= g_lv;
            h_reg   <= g_h;
            w_reg   <= g_w;
            len_reg <= g_len;
            p_reg   <= g_p;
            rem_reg <= '0;
            dvd_reg <= rotate_steps_reg;
            cnt_reg <= '1;
        end
        if (state_reg == grr_pkg::ST_DIV) begin
            if (div_trial >= {1'b0, len_reg}) begin
                rem_reg <= LEN_W'(div_trial - {1'b0, len_reg});
            end else begin
                rem_reg <= LEN_W'(div_trial);
            end
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (state_reg == grr_pkg::ST_MODQ) begin
            if (q_sum >= {1'b0, len_reg}) begin
                q_reg <= LEN_W'(q_sum - {1'b0, len_reg});
            end else begin
                q_reg <= LEN_W'(q_sum);
            end
        end
        if (state_reg == grr_pkg::ST_MAP) begin
            sr_reg <= DIM_W'(msr);
            sc_reg <= DIM_W'(msc);
        end
    end

    // Grid memory: write on a write request, registered read for a rotated read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[wr_addr] <= in_value;
        end
        if (state_reg == grr_pkg::ST_READ) begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (load_out) begin
            m_tdata_reg <= zero_reg ? '0 : rd_data_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The remainder and the start position stay inside the ring while dividing.
    a_rem_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == grr_pkg::ST_DIV) |-> (rem_reg < len_reg && p_reg < len_reg))
        else $error("divider remainder or start position outside the ring");

    // The wrapped position lies on the ring.
    a_q_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == grr_pkg::ST_MAP) |-> (q_reg < len_reg))
        else $error("wrapped ring position out of range");

    // The source cell lies on the same ring as the query.
    a_src_on_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == grr_pkg::ST_READ) |->
        (sr_reg >= lv_reg && sc_reg >= lv_reg &&
         sr_reg < lv_reg + h_reg && sc_reg < lv_reg + w_reg))
        else $error("source cell off the ring");

    // An accepted read keeps the block busy on the next cycle.
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == grr_pkg::CMD_READ) |=> !s_tready)
        else $error("request taken while a read is in flight");

endmodule

@@ tb/tb_grid_ring_rotate.sv @@
`timescale 1ns / 100ps

module tb_grid_ring_rotate;

    localparam int GRID_COLS    = 64;
    localparam int SETTLE_WAIT  = 50;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 3000;
    localparam int BATCH_ITEMS  = 30;
    localparam int BATCHES      = 5;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [grr_pkg::CFG_A_W-1:0]    cfg_addr  = '0;
    logic [grr_pkg::CFG_D_W-1:0]    cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [grr_pkg::S_DATA_W-1:0]   s_tdata   = '0;   // row[5:0], col[11:6], value[43:12]
    logic                           s_tuser   = 1'b0; // cmd[0]
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [grr_pkg::DATA_W-1:0]     m_tdata;          // rotated_value[31:0]

    // Shadow copy of the configuration and the grid contents.
    logic [grr_pkg::HALF_W-1:0]     half_rows_reg = 6'd1;
    logic [grr_pkg::HALF_W-1:0]     half_cols_reg = 6'd1;
    logic [grr_pkg::STEP_W-1:0]     steps_reg     = '0;
    logic [grr_pkg::DATA_W-1:0]     grid_mem [0:4095];
    bit                             cell_written [0:4095];
    logic [grr_pkg::DATA_W-1:0]     pending_values [$];

    int unsigned           mismatch_count = 0;
    int unsigned           quiet_cycles   = 0;
    int unsigned           src_idle_pct   = 0;
    int unsigned           snk_idle_pct   = 0;
    int unsigned           hold_left      = 0;
    bit                    hold_ask       = 1'b0;

    grid_ring_rotate DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Zero maps to one and anything above the maximum saturates.
    function automatic int unsigned eff_half(input logic [grr_pkg::HALF_W-1:0] v);
        if (v == 0) return 1;
        if (v > 32) return 32;
        return v;
    endfunction

    // Finds the cell whose element lands on (r, c) after the ring rotation.
    // Returns 0 when (r, c) lies outside the current grid.
    function automatic bit source_cell(input int unsigned r, input int unsigned c,
                                       output int unsigned sr, output int unsigned sc);
        int unsigned nr, nc, lv, h, w, len, p, q;
        nr = 2 * eff_half(half_rows_reg);
        nc = 2 * eff_half(half_cols_reg);
        sr = 0;
        sc = 0;
        if (r >= nr || c >= nc) return 1'b0;

        lv = r;
        if (c < lv) lv = c;
        if (nr - 1 - r < lv) lv = nr - 1 - r;
        if (nc - 1 - c < lv) lv = nc - 1 - c;
        h = nr - 2 * lv;
        w = nc - 2 * lv;
        len = 2 * (h + w) - 4;

        // Clockwise position starting at the ring's top-left corner.
        if (r == lv)
            p = c - lv;
        else if (c == lv + w - 1)
            p = (w - 1) + (r - lv);
        else if (r == lv + h - 1)
            p = (w - 1) + (h - 1) + (lv + w - 1 - c);
        else
            p = 2 * (w - 1) + (h - 1) + (lv + h - 1 - r);

        q = (p + steps_reg % len) % len;

        if (q < w) begin
            sr = lv;
            sc = lv + q;
        end else if (q < w + h - 1) begin
            sr = lv + (q - (w - 1));
            sc = lv + w - 1;
        end else if (q < 2 * (w - 1) + h) begin
            sr = lv + h - 1;
            sc = lv + w - 1 - (q - (w - 1) - (h - 1));
        end else begin
            sr = lv + h - 1 - (q - 2 * (w - 1) - (h - 1));
            sc = lv;
        end
        return 1'b1;
    endfunction

    // Updates the grid copy or queues the rotated value a request will return.
    function automatic void predict_rotation(input logic cmd, input int unsigned r,
                                             input int unsigned c,
                                             input logic [grr_pkg::DATA_W-1:0] v);
        int unsigned sr, sc;
        if (cmd == grr_pkg::CMD_WRITE) begin
            if (r < 2 * eff_half(half_rows_reg) && c < 2 * eff_half(half_cols_reg)) begin
                grid_mem[r * GRID_COLS + c]     = v;
                cell_written[r * GRID_COLS + c] = 1'b1;
            end
        end else if (source_cell(r, c, sr, sc)) begin
            pending_values.push_back(grid_mem[sr * GRID_COLS + sc]);
        end else begin
            pending_values.push_back('0);
        end
    endfunction

    // Offers one request, with random idle cycles ahead of it, until it is taken.
    task automatic send_request(input logic cmd, input logic [grr_pkg::IDX_W-1:0] r,
                                input logic [grr_pkg::IDX_W-1:0] c,
                                input logic [grr_pkg::DATA_W-1:0] v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, v, c, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_rotation(cmd, r, c, v);
    endtask

    // Reads a cell, first storing its source if that entry was never written.
    task automatic read_cell(input logic [grr_pkg::IDX_W-1:0] r,
                             input logic [grr_pkg::IDX_W-1:0] c);
        int unsigned sr, sc;
        if (source_cell(r, c, sr, sc) && !cell_written[sr * GRID_COLS + sc])
            send_request(grr_pkg::CMD_WRITE, sr[grr_pkg::IDX_W-1:0],
                         sc[grr_pkg::IDX_W-1:0], $urandom);
        send_request(grr_pkg::CMD_READ, r, c, $urandom);
    endtask

    // Waits until every pending result has arrived and the block has gone quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_values.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    // Writes all three registers back to back.
    task automatic configure(input logic [grr_pkg::CFG_D_W-1:0] hr,
                             input logic [grr_pkg::CFG_D_W-1:0] hc,
                             input logic [grr_pkg::CFG_D_W-1:0] steps);
        cfg_we    <= 1'b1;
        cfg_addr  <= grr_pkg::REG_HALF_ROWS;
        cfg_wdata <= hr;
        @(posedge aclk);
        half_rows_reg = hr[grr_pkg::HALF_W-1:0];
        cfg_addr  <= grr_pkg::REG_HALF_COLS;
        cfg_wdata <= hc;
        @(posedge aclk);
        half_cols_reg = hc[grr_pkg::HALF_W-1:0];
        cfg_addr  <= grr_pkg::REG_ROTATE_STEPS;
        cfg_wdata <= steps;
        @(posedge aclk);
        steps_reg = steps;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [grr_pkg::CFG_D_W-1:0] pick_half();
        logic [grr_pkg::CFG_D_W-1:0] v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = 32;
            2:       v = $urandom_range(33, 63);
            3:       v = $urandom_range(1, 63);
            default: v = $urandom_range(1, 4);
        endcase
        // Upper bits of the write data fall outside the register.
        if ($urandom_range(3) == 0) v = v | ($urandom & ~32'h3F);
        return v;
    endfunction

    function automatic logic [grr_pkg::STEP_W-1:0] pick_steps();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1, 300);
            default: return $urandom;
        endcase
    endfunction

    // Smallest grid: every cell, extreme values, no shift and the largest shift.
    task automatic test_min_grid();
        configure(1, 1, 0);
        send_request(grr_pkg::CMD_WRITE, 0, 0, 32'h8000_0000);
        send_request(grr_pkg::CMD_WRITE, 0, 1, 32'h7FFF_FFFF);
        send_request(grr_pkg::CMD_WRITE, 1, 1, 32'h0000_0000);
        send_request(grr_pkg::CMD_WRITE, 1, 0, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_request(grr_pkg::CMD_READ, grr_pkg::IDX_W'(i / 2),
                         grr_pkg::IDX_W'(i % 2), '1);
        drain();
        configure(1, 1, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_request(grr_pkg::CMD_READ, grr_pkg::IDX_W'(i / 2),
                         grr_pkg::IDX_W'(i % 2), '0);
        drain();
    endtask

    // Half sizes of zero and above the maximum, accesses outside the grid and
    // elements kept across a size change.
    task automatic test_size_limits();
        logic [grr_pkg::DATA_W-1:0] kept;
        kept = $urandom;
        configure(32, 32, 0);
        send_request(grr_pkg::CMD_WRITE, 5, 1, kept);
        drain();
        configure(0, 63, 5);
        send_request(grr_pkg::CMD_WRITE, 5, 1, ~kept);
        send_request(grr_pkg::CMD_READ, 2, 0, $urandom);
        send_request(grr_pkg::CMD_READ, 63, 63, $urandom);
        read_cell(1, 63);
        read_cell(0, 0);
        drain();
        configure(40, 32, 0);
        send_request(grr_pkg::CMD_READ, 5, 1, $urandom);
        drain();
    endtask

    // Largest grid with the largest shift, corners and the innermost ring.
    task automatic test_max_grid();
        configure(32, 32, 32'hFFFF_FFFF);
        read_cell(0, 0);
        read_cell(63, 63);
        read_cell(31, 32);
        read_cell(32, 31);
        read_cell(0, 63);
        drain();
    endtask

    // Random configurations, each followed by a batch of mixed requests.
    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct);
        int unsigned nr, nc;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int b = 0; b < BATCHES; b++) begin
            configure(pick_half(), pick_half(), pick_steps());
            nr = 2 * eff_half(half_rows_reg);
            nc = 2 * eff_half(half_cols_reg);
            for (int i = 0; i < BATCH_ITEMS; i++) begin
                case ($urandom_range(9))
                    0, 1, 2: send_request(grr_pkg::CMD_WRITE,
                                          grr_pkg::IDX_W'($urandom_range(nr - 1)),
                                          grr_pkg::IDX_W'($urandom_range(nc - 1)), $urandom);
                    3:       send_request(grr_pkg::CMD_WRITE,
                                          grr_pkg::IDX_W'($urandom_range(63)),
                                          grr_pkg::IDX_W'($urandom_range(63)), $urandom);
                    4:       read_cell(grr_pkg::IDX_W'($urandom_range(63)),
                                       grr_pkg::IDX_W'($urandom_range(63)));
                    default: read_cell(grr_pkg::IDX_W'($urandom_range(nr - 1)),
                                       grr_pkg::IDX_W'($urandom_range(nc - 1)));
                endcase
            end
            drain();
        end
    endtask

    // The receiver stops for a long stretch while reads keep coming.
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        configure(3, 2, $urandom);
        hold_ask <= 1'b1;
        for (int i = 0; i < 30; i++)
            read_cell(grr_pkg::IDX_W'($urandom_range(5)), grr_pkg::IDX_W'($urandom_range(3)));
        drain();
    endtask

    // Receiver readiness, with an optional long hold-off.
    always @(posedge aclk) begin
        if (hold_ask) begin
            hold_ask  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Each result is compared with the oldest pending value.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                if (m_tdata !== pending_values[0]) begin
                    $display("%0t: rotated value mismatch, expected %h, got %h",
                             $time, pending_values[0], m_tdata);
                    mismatch_count++;
                end
                void'(pending_values.pop_front());
            end
        end
    end

    // Watchdog on cycles in which no request and no result moves.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_min_grid();
        test_size_limits();
        test_max_grid();
        test_random_traffic(37, 57);
        test_random_traffic(57, 37);
        test_random_traffic(0, 0);
        test_backpressure();

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/grr_pkg.sv
sv/grid_ring_rotate.sv
tb/tb_grid_ring_rotate.sv
